>>> src/script_tokenizer_assert.svh
`ifndef SCRIPT_TOKENIZER_ASSERT_SVH
`define SCRIPT_TOKENIZER_ASSERT_SVH

// checked while reset is released
`define STOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define STOK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/stok_pkg.sv
package stok_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [32:0] SRC_MAX_BYTES = 33'd16777216;
  localparam logic [19:0] LIMIT_RESET = 20'd100000;
  localparam logic [62:0] INT_TOP = {63{1'b1}};
  localparam logic [13:0] KW_ALL = {14{1'b1}};
  localparam int unsigned RES_MAX = 3;

  // token kinds with a meaning of their own
  localparam logic [5:0] TK_EOF = 6'd0;
  localparam logic [5:0] TK_DOT = 6'd9;
  localparam logic [5:0] TK_STRING = 6'd32;
  localparam logic [5:0] TK_INT = 6'd33;
  localparam logic [5:0] TK_DEC = 6'd34;
  localparam logic [5:0] TK_IDENT = 6'd35;
  localparam logic [5:0] TK_KW0 = 6'd36;
  localparam logic [5:0] TK_BAD = 6'd50;
  localparam logic [5:0] TK_UNTERM = 6'd51;
  localparam logic [5:0] TK_LIMIT = 6'd52;

  // operator codes
  localparam logic [3:0] OP_SLASH = 4'd3;
  localparam logic [3:0] OP_AMP = 4'd9;
  localparam logic [3:0] OP_BAR = 4'd10;
  localparam logic [3:0] OP_COUNT = 4'd11;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_OP      = 4'd1,
    M_COMMENT = 4'd2,
    M_STRING  = 4'd3,
    M_ESC     = 4'd4,
    M_INT     = 4'd5,
    M_INTDOT  = 4'd6,
    M_DEC     = 4'd7,
    M_IDENT   = 4'd8
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] start;
    logic [24:0] len;
    logic [24:0] line;
    logic [24:0] col;
    logic [62:0] val;
    logic        ovf;
  } res_t;

  typedef struct packed {
    res_t [2:0] r;
    logic [1:0] cnt;
  } bundle_t;

  // keyword spelling, one byte per position
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] pos);
    logic [63:0] txt;
    txt = '0;
    case (k)
      4'd0:  txt = {"if", 48'd0};
      4'd1:  txt = {"else", 32'd0};
      4'd2:  txt = {"elif", 32'd0};
      4'd3:  txt = {"for", 40'd0};
      4'd4:  txt = {"while", 24'd0};
      4'd5:  txt = {"do", 48'd0};
      4'd6:  txt = {"set", 40'd0};
      4'd7:  txt = {"let", 40'd0};
      4'd8:  txt = {"declare", 8'd0};
      4'd9:  txt = {"return", 16'd0};
      4'd10: txt = {"true", 32'd0};
      4'd11: txt = {"false", 24'd0};
      4'd12: txt = {"null", 32'd0};
      4'd13: txt = {"expr", 32'd0};
      default: txt = '0;
    endcase
    if (pos[3]) return 8'd0;
    return txt[63 - 8 * pos[2:0] -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd5: return 4'd2;
      4'd3, 4'd6, 4'd7: return 4'd3;
      4'd4, 4'd11: return 4'd5;
      4'd8: return 4'd7;
      4'd9: return 4'd6;
      default: return 4'd4;
    endcase
  endfunction

  function automatic logic [7:0] punct_char(input logic [3:0] i);
    case (i)
      4'd0: return "(";
      4'd1: return ")";
      4'd2: return "{";
      4'd3: return "}";
      4'd4: return "[";
      4'd5: return "]";
      4'd6: return ";";
      4'd7: return ",";
      4'd8: return ".";
      4'd9: return "#";
      default: return "@";
    endcase
  endfunction

  function automatic logic [7:0] op_char(input logic [3:0] i);
    case (i)
      4'd0: return "+";
      4'd1: return "-";
      4'd2: return "*";
      4'd3: return "/";
      4'd4: return "%";
      4'd5: return "=";
      4'd6: return "!";
      4'd7: return "<";
      4'd8: return ">";
      4'd9: return "&";
      default: return "|";
    endcase
  endfunction

endpackage

>>> src/script_tokenizer.sv
// a token word is queued with the input word that decides it, then offered
// throughput: one input word per cycle; one result word per cycle while out_ready
// an input word makes up to three results, a four-entry queue takes bursts
// input stalls only when that queue is full
// reset (synchronous, rst_n low) clears scan state and sets token_limit to 100000
module script_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = stok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [19:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [23:0] out_start_offset,
  output logic [24:0] out_lexeme_length,
  output logic [24:0] out_line_number,
  output logic [24:0] out_column_number,
  output logic [62:0] out_integer_value,
  output logic        out_value_overflow,
  output logic        out_last_result
);
  import stok_pkg::*;

  logic    q_push, q_pop, q_full, q_empty;
  bundle_t q_wdata, q_head;

  stok_front u_front (
    .clk, .rst_n, .cfg_write_en, .cfg_write_data,
    .in_valid, .in_ready, .in_data_byte, .in_has_byte, .in_end_of_source,
    .q_full, .q_push, .q_data(q_wdata)
  );

  stok_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  stok_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop,
    .out_valid, .out_ready, .out_token_kind, .out_start_offset, .out_lexeme_length,
    .out_line_number, .out_column_number, .out_integer_value, .out_value_overflow,
    .out_last_result
  );

endmodule

>>> src/stok_front.sv
module stok_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [19:0]       cfg_write_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_byte,
  input  logic              in_end_of_source,
  input  logic              q_full,
  output logic              q_push,
  output stok_pkg::bundle_t q_data
);
  import stok_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  op;
    logic [23:0] tstart;
    logic [24:0] off;
    logic [24:0] line;
    logic [24:0] col;
    logic [24:0] scol;
    logic [62:0] acc;
    logic        ovf;
    logic [13:0] kwc;
    logic [3:0]  idlen;
    logic [20:0] ntok;
    logic        lim;
    logic        gap;
  } lex_t;

  lex_t        st_r, st_nxt;
  logic [19:0] limit_r;
  bundle_t     bd;
  logic        accept;

  function automatic lex_t lex_reset();
    lex_t s;
    s = '0;
    s.mode = M_IDLE;
    s.line = 25'd1;
    s.col = 25'd1;
    s.scol = 25'd1;
    s.kwc = KW_ALL;
    return s;
  endfunction

  function automatic logic stopped(inout lex_t s, input logic [19:0] lim);
    if (s.ntok >= {1'b0, lim}) s.lim = 1'b1;
    return s.lim;
  endfunction

  function automatic void emit(inout lex_t s, inout bundle_t b, input logic [5:0] kind,
                               input logic [23:0] start, input logic [24:0] len,
                               input logic [24:0] col, input logic [62:0] val,
                               input logic ovf, input logic counted);
    if (b.cnt != 2'd3) begin
      b.r[b.cnt].kind = kind;
      b.r[b.cnt].start = start;
      b.r[b.cnt].len = len;
      b.r[b.cnt].line = s.line;
      b.r[b.cnt].col = col;
      b.r[b.cnt].val = val;
      b.r[b.cnt].ovf = ovf;
      b.cnt = b.cnt + 2'd1;
    end
    if (counted) begin
      s.ntok = s.ntok + 21'd1;
      s.gap = 1'b0;
    end
  endfunction

  function automatic void consume(inout lex_t s);
    s.off = s.off + 25'd1;
    s.col = s.col + 25'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c[7];
  endfunction

  function automatic void ident_take(inout lex_t s, input logic [7:0] c);
    for (int k = 0; k < 14; k++) begin
      if (s.idlen >= kw_len(4'(k)) || kw_char(4'(k), s.idlen) != c) s.kwc[k] = 1'b0;
    end
    if (s.idlen != 4'd15) s.idlen = s.idlen + 4'd1;
    consume(s);
  endfunction

  function automatic void accumulate(inout lex_t s, input logic [7:0] c);
    logic [66:0] wide;
    wide = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {63'd0, c[3:0] - 4'd0};
    if (wide > {4'd0, INT_TOP}) begin
      s.acc = INT_TOP;
      s.ovf = 1'b1;
    end else begin
      s.acc = wide[62:0];
    end
    consume(s);
  endfunction

  function automatic void emit_ident(inout lex_t s, inout bundle_t b);
    logic [5:0] kind;
    kind = TK_IDENT;
    for (int k = 0; k < 14; k++) begin
      if (s.kwc[k] && kw_len(4'(k)) == s.idlen) kind = TK_KW0 + 6'(k);
    end
    emit(s, b, kind, s.tstart, s.off - {1'b0, s.tstart}, s.col, '0, 1'b0, 1'b1);
  endfunction

  function automatic void emit_int(inout lex_t s, inout bundle_t b);
    emit(s, b, TK_INT, s.tstart, s.off - {1'b0, s.tstart}, s.col, s.acc, s.ovf, 1'b1);
  endfunction

  function automatic logic [5:0] op_single(input logic [3:0] op);
    if (op < OP_AMP) return 6'd12 + {1'b0, op, 1'b0};
    return TK_BAD;
  endfunction

  function automatic logic [5:0] op_double(input logic [3:0] op);
    if (op < OP_AMP) return 6'd13 + {1'b0, op, 1'b0};
    if (op == OP_AMP) return 6'd30;
    return 6'd31;
  endfunction

  function automatic logic [7:0] op_second(input logic [3:0] op);
    if (op == OP_AMP) return "&";
    if (op == OP_BAR) return "|";
    return "=";
  endfunction

  // resolves held digits and dot into integer then dot, returns stop
  function automatic logic flush_int_dot(inout lex_t s, inout bundle_t b, input logic [19:0] lim);
    logic [24:0] om1;
    om1 = s.off - 25'd1;
    emit(s, b, TK_INT, s.tstart, om1 - {1'b0, s.tstart}, s.scol, s.acc, s.ovf, 1'b1);
    if (stopped(s, lim)) begin
      s.off = om1;
      s.col = s.scol;
      return 1'b1;
    end
    emit(s, b, TK_DOT, om1[23:0], 25'd1, s.col, '0, 1'b0, 1'b1);
    return stopped(s, lim);
  endfunction

  function automatic void idle_byte(inout lex_t s, inout bundle_t b, input logic [7:0] c);
    logic [23:0] so;
    logic        done;
    done = 1'b0;
    so = s.off[23:0];
    if (c == " " || c == 8'h09 || c == 8'h0d) begin
      consume(s);
      s.gap = 1'b1;
      done = 1'b1;
    end else if (c == 8'h0a) begin
      s.off = s.off + 25'd1;
      s.line = s.line + 25'd1;
      s.col = 25'd1;
      s.gap = 1'b1;
      done = 1'b1;
    end
    for (int i = 0; i < 11; i++) begin
      if (!done && punct_char(4'(i)) == c) begin
        consume(s);
        emit(s, b, 6'(i + 1), so, 25'd1, s.col, '0, 1'b0, 1'b1);
        done = 1'b1;
      end
    end
    for (int i = 0; i < 11; i++) begin
      if (!done && op_char(4'(i)) == c) begin
        s.tstart = so;
        s.op = 4'(i);
        consume(s);
        s.mode = M_OP;
        done = 1'b1;
      end
    end
    if (!done) begin
      if (c == "\"") begin
        consume(s);
        s.tstart = s.off[23:0];
        s.mode = M_STRING;
      end else if (is_digit(c)) begin
        s.tstart = so;
        s.acc = '0;
        s.ovf = 1'b0;
        accumulate(s, c);
        s.mode = M_INT;
      end else if (is_alpha(c)) begin
        s.tstart = so;
        s.kwc = KW_ALL;
        s.idlen = 4'd0;
        ident_take(s, c);
        s.mode = M_IDENT;
      end else begin
        consume(s);
        emit(s, b, TK_BAD, so, 25'd1, s.col, '0, 1'b0, 1'b1);
      end
    end
  endfunction

  function automatic void feed(inout lex_t s, inout bundle_t b, input logic [7:0] c,
                               input logic [19:0] lim);
    logic go_idle;
    go_idle = 1'b0;
    unique case (s.mode)
      M_OP: begin
        if (s.op == OP_SLASH && c == "/") begin
          consume(s);
          s.gap = 1'b1;
          s.mode = M_COMMENT;
        end else if (s.op < OP_COUNT && c == op_second(s.op)) begin
          consume(s);
          emit(s, b, op_double(s.op), s.tstart, 25'd2, s.col, '0, 1'b0, 1'b1);
          s.mode = M_IDLE;
        end else begin
          emit(s, b, op_single(s.op), s.tstart, 25'd1, s.col, '0, 1'b0, 1'b1);
          s.mode = M_IDLE;
          go_idle = !stopped(s, lim);
        end
      end
      M_COMMENT: begin
        if (c != 8'h0a) begin
          consume(s);
        end else begin
          s.mode = M_IDLE;
          go_idle = 1'b1;
        end
      end
      M_STRING: begin
        consume(s);
        if (c == "\\") begin
          s.mode = M_ESC;
        end else if (c == "\"") begin
          emit(s, b, TK_STRING, s.tstart, s.off - {1'b0, s.tstart}, s.col, '0, 1'b0, 1'b1);
          s.mode = M_IDLE;
        end
      end
      M_ESC: begin
        consume(s);
        s.mode = M_STRING;
      end
      M_INT: begin
        if (is_digit(c)) begin
          accumulate(s, c);
        end else if (c == ".") begin
          s.scol = s.col;
          consume(s);
          s.mode = M_INTDOT;
        end else begin
          emit_int(s, b);
          s.mode = M_IDLE;
          go_idle = !stopped(s, lim);
        end
      end
      M_INTDOT: begin
        if (is_digit(c)) begin
          consume(s);
          s.mode = M_DEC;
        end else begin
          s.mode = M_IDLE;
          go_idle = !flush_int_dot(s, b, lim);
        end
      end
      M_DEC: begin
        if (is_digit(c)) begin
          consume(s);
        end else begin
          emit(s, b, TK_DEC, s.tstart, s.off - {1'b0, s.tstart}, s.col, '0, 1'b0, 1'b1);
          s.mode = M_IDLE;
          go_idle = !stopped(s, lim);
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          ident_take(s, c);
        end else begin
          emit_ident(s, b);
          s.mode = M_IDLE;
          go_idle = !stopped(s, lim);
        end
      end
      default: begin
        s.mode = M_IDLE;
        go_idle = 1'b1;
      end
    endcase
    if (go_idle) idle_byte(s, b, c);
  endfunction

  function automatic void finish(inout lex_t s, inout bundle_t b, input logic [19:0] lim);
    logic unused_stop;
    unused_stop = 1'b0;
    if (!stopped(s, lim)) begin
      unique case (s.mode)
        M_OP:
          emit(s, b, op_single(s.op), s.tstart, 25'd1, s.col, '0, 1'b0, 1'b1);
        M_STRING, M_ESC:
          emit(s, b, TK_UNTERM, s.tstart, 25'd0, s.col, '0, 1'b0, 1'b1);
        M_INT: emit_int(s, b);
        M_INTDOT: unused_stop = flush_int_dot(s, b, lim);
        M_DEC:
          emit(s, b, TK_DEC, s.tstart, s.off - {1'b0, s.tstart}, s.col, '0, 1'b0, 1'b1);
        M_IDENT: emit_ident(s, b);
        default: if (s.gap) s.ntok = s.ntok + 21'd1;
      endcase
    end
    emit(s, b, stopped(s, lim) ? TK_LIMIT : TK_EOF, 24'd0, 25'd0, s.col, '0, unused_stop & 1'b0,
         1'b0);
    s = lex_reset();
  endfunction

  // one input word through the lexer
  always_comb begin
    st_nxt = st_r;
    bd = '0;
    if (in_has_byte && !stopped(st_nxt, limit_r) && {8'd0, st_nxt.off} < SRC_MAX_BYTES) begin
      feed(st_nxt, bd, in_data_byte, limit_r);
    end
    if (in_end_of_source) finish(st_nxt, bd, limit_r);
  end

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign q_push = accept && (bd.cnt != 2'd0);
  assign q_data = bd;

  // lexer state and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lex_reset();
      limit_r <= LIMIT_RESET;
    end else begin
      if (accept) st_r <= st_nxt;
      if (cfg_write_en) limit_r <= cfg_write_data;
    end
  end

endmodule

>>> src/stok_queue.sv
module stok_queue #(
  parameter int unsigned DEPTH = stok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stok_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output stok_pkg::bundle_t head
);
  import stok_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  bundle_t        mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign head = mem_r[rptr_r];

  // pointer and fill update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST) ? '0 : wptr_r + PW'(1);
      cnt_nxt = cnt_nxt + CW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST) ? '0 : rptr_r + PW'(1);
      cnt_nxt = cnt_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

>>> src/stok_back.sv
module stok_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  stok_pkg::bundle_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        out_token_kind,
  output logic [23:0]       out_start_offset,
  output logic [24:0]       out_lexeme_length,
  output logic [24:0]       out_line_number,
  output logic [24:0]       out_column_number,
  output logic [62:0]       out_integer_value,
  output logic              out_value_overflow,
  output logic              out_last_result
);
  import stok_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  res_t       cur;
  logic       fire;

  assign cur = q_head.r[idx_r];
  assign out_valid = !q_empty;
  assign out_last_result = idx_r == q_head.cnt - 2'd1;
  assign fire = out_valid && out_ready;
  assign q_pop = fire && out_last_result;

  assign out_token_kind = cur.kind;
  assign out_start_offset = cur.start;
  assign out_lexeme_length = cur.len;
  assign out_line_number = cur.line;
  assign out_column_number = cur.col;
  assign out_integer_value = cur.val;
  assign out_value_overflow = cur.ovf;

  // walk the results of the head entry
  always_comb begin
    idx_nxt = idx_r;
    if (q_pop) idx_nxt = 2'd0;
    else if (fire) idx_nxt = idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else idx_r <= idx_nxt;
  end

endmodule

>>> src/stok_checker.sv
`include "script_tokenizer_assert.svh"

module stok_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_token_kind,
  input logic [24:0] out_column_number,
  input logic        out_last_result
);
  import stok_pkg::*;

  // a stalled word stays offered
  `STOK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out word dropped")

  // a stalled word keeps its kind and column
  `STOK_ASSERT(a_out_stable,
    out_valid && !out_ready |=> $stable(out_token_kind) && $stable(out_column_number),
    "out word changed while stalled")

  // nothing offered right after reset
  `STOK_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "out valid after reset")

  // the end token closes its input word
  `STOK_ASSERT(a_eof_last,
    out_valid && out_token_kind == TK_EOF |-> out_last_result, "end token not last")

  // columns count from one
  `STOK_ASSERT(a_col_pos, out_valid |-> out_column_number != 25'd0, "zero column")

endmodule

bind script_tokenizer stok_checker u_stok_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_token_kind, .out_column_number, .out_last_result
);
